>>> hw/rtl/ufs_pkg.sv
package ufs_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
    localparam int unsigned CP_W        = 21;
    localparam int unsigned HELD_DEPTH  = 3;
    localparam int unsigned HELD_IDX_W  = 2;
    localparam int unsigned LEN_W       = 3;

    localparam logic [BYTE_W-1:0] REPLACE_RESET = 8'h20;

    // sequence lengths held in the length register
    localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // byte class masks and patterns
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

    // filtered code point ranges, upper bounds exclusive
    localparam logic [CP_W-1:0] EMOJI_LO = 21'h1F000;
    localparam logic [CP_W-1:0] EMOJI_HI = 21'h1FFFF;
    localparam logic [CP_W-1:0] DINGB_LO = 21'h02700;
    localparam logic [CP_W-1:0] DINGB_HI = 21'h027BF;
    localparam logic [CP_W-1:0] TECH_LO  = 21'h02300;
    localparam logic [CP_W-1:0] TECH_HI  = 21'h024FF;

    typedef logic [BYTE_W-1:0] byte_t;

    // all results caused by one input item
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                   count;
        logic                               text_end;
    } ufs_burst_t;

    function automatic logic ufs_is_filtered(input logic [CP_W-1:0] cp);
        return (cp >= EMOJI_LO && cp < EMOJI_HI) ||
               (cp >= DINGB_LO && cp < DINGB_HI) ||
               (cp >= TECH_LO  && cp < TECH_HI);
    endfunction

endpackage

>>> hw/rtl/ufs_in_if.sv
interface ufs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

>>> hw/rtl/ufs_out_if.sv
interface ufs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output text_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input text_end, output ready);
endinterface

>>> hw/rtl/ufs_cfg_if.sv
interface ufs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] replacement_byte;

    modport source (output valid, output replacement_byte, input ready);
    modport sink   (input valid, input replacement_byte, output ready);
endinterface

>>> hw/rtl/ufs_decoder.sv
module ufs_decoder (
    input  logic              clk,
    input  logic              rst_n,
    ufs_in_if.sink            in_ch,
    input  ufs_pkg::byte_t    replace_byte,
    input  logic              take,
    output logic              push,
    output ufs_pkg::ufs_burst_t burst
);
    import ufs_pkg::*;

    logic                  in_valid_reg;
    byte_t                 in_byte_reg;
    logic                  in_eot_reg;
    logic                  advance;

    byte_t                 pend_reg  [HELD_DEPTH];
    byte_t                 pend_next [HELD_DEPTH];
    logic [LEN_W-1:0]      seq_reg, seq_next;
    logic [HELD_IDX_W-1:0] br_reg, br_next;
    logic [CP_W-1:0]       acc_reg, acc_next;

    logic [CP_W-1:0]       acc_shift;
    logic [LEN_W-1:0]      br_plus;
    logic                  is_cont;
    logic                  start_new;
    byte_t                 b;

    assign advance     = in_valid_reg && take;
    assign in_ch.ready = !in_valid_reg || take;
    assign push        = advance && (burst.count != '0);

    assign b         = in_byte_reg;
    assign acc_shift = {acc_reg[CP_W-7:0], b[5:0]};
    assign br_plus   = {1'b0, br_reg} + 3'd1;
    assign is_cont   = (b & CONT_MASK) == CONT_PAT;

    always_comb
    begin
        seq_next  = seq_reg;
        br_next   = br_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        burst     = '0;
        start_new = 1'b0;

        if (in_eot_reg)
        begin
            seq_next       = LEN_NONE;
            br_next        = '0;
            acc_next       = '0;
            burst.count    = CNT_W'(1);
            burst.text_end = 1'b1;
        end
        else
        begin
            start_new = 1'b1;
            if (seq_reg != LEN_NONE)
            begin
                // any non-continuation byte aborts the pending sequence
                seq_next = LEN_NONE;
                br_next  = '0;
                acc_next = '0;
                if (is_cont)
                begin
                    start_new = 1'b0;
                    if (br_plus >= seq_reg)
                    begin
                        if (ufs_is_filtered(acc_shift))
                        begin
                            burst.bytes[0] = replace_byte;
                            burst.count    = CNT_W'(1);
                        end
                        else
                        begin
                            // held bytes first, then this byte; slots past count unused
                            for (int i = 0; i < HELD_DEPTH; i++)
                            begin
                                if (HELD_IDX_W'(i) == br_reg)
                                    burst.bytes[i] = b;
                                else
                                    burst.bytes[i] = pend_reg[i];
                            end
                            burst.bytes[MAX_RESULTS-1] = b;
                            burst.count = CNT_W'(br_plus);
                        end
                    end
                    else if (br_reg != HELD_IDX_W'(HELD_DEPTH))
                    begin
                        pend_next[br_reg] = b;
                        seq_next          = seq_reg;
                        br_next           = br_reg + 1'b1;
                        acc_next          = acc_shift;
                    end
                end
            end

            if (start_new)
            begin
                if ((b & ASCII_MASK) == '0)
                begin
                    burst.bytes[0] = b;
                    burst.count    = CNT_W'(1);
                end
                else if ((b & LEAD2_MASK) == LEAD2_PAT)
                begin
                    pend_next[0] = b;
                    seq_next     = LEN_TWO;
                    br_next      = HELD_IDX_W'(1);
                    acc_next     = CP_W'(b[4:0]);
                end
                else if ((b & LEAD3_MASK) == LEAD3_PAT)
                begin
                    pend_next[0] = b;
                    seq_next     = LEN_THREE;
                    br_next      = HELD_IDX_W'(1);
                    acc_next     = CP_W'(b[3:0]);
                end
                else if ((b & LEAD4_MASK) == LEAD4_PAT)
                begin
                    pend_next[0] = b;
                    seq_next     = LEN_FOUR;
                    br_next      = HELD_IDX_W'(1);
                    acc_next     = CP_W'(b[2:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            seq_reg      <= LEN_NONE;
            br_reg       <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                seq_reg <= seq_next;
                br_reg  <= br_next;
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_eot_reg  <= in_ch.end_of_text;
        end
        if (advance)
            pend_reg <= pend_next;
    end

endmodule

>>> hw/rtl/ufs_serializer.sv
module ufs_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ufs_pkg::ufs_burst_t burst,
    output logic                take,
    ufs_out_if.source           out_ch
);
    import ufs_pkg::*;

    logic                              valid_reg;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes_reg;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [IDX_W-1:0]                  idx_reg;
    logic                              end_reg;
    logic                              last;

    assign last = idx_reg == IDX_W'(cnt_reg - CNT_W'(1));
    assign take = !valid_reg || (out_ch.ready && last);

    assign out_ch.valid      = valid_reg;
    assign out_ch.out_byte   = end_reg ? '0 : bytes_reg[idx_reg];
    assign out_ch.byte_valid = !end_reg;
    assign out_ch.run_last   = last;
    assign out_ch.text_end   = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ch.ready)
        begin
            if (last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bytes_reg <= burst.bytes;
            cnt_reg   <= burst.count;
            end_reg   <= burst.text_end;
        end
    end

endmodule

>>> hw/rtl/utf8_emoji_strip_filter_top.sv
// utf8 text filter that strips emoji and symbol code points
// in_ch  : one item per text byte (data_byte) or an end marker (end_of_text set)
// out_ch : result items, the original bytes of each finished code point, or the
//          replacement byte when the code point falls in an emoji/symbol range;
//          run_last flags the last result of an input item, text_end the end marker
// cfg_ch : writes the replacement byte, taken in any cycle (ready held high)
// path: an accepted item waits in the input register until the result register takes
//          it, is decoded into the result register and its results go out on out_ch
// throughput: 1 item per cycle while out_ch is ready and each item yields at most one
//          result; an item finishing a multibyte sequence yields up to 4 results, sent
//          one per cycle from the result register; the input waits until the last one leaves
// reset clears the pending sequence and sets the replacement byte to a space
// when the receiver stalls the result register holds, one more item waits in the
// input register, then in_ch.ready drops
module utf8_emoji_strip_filter_top (
    input  logic      clk,
    input  logic      rst_n,
    ufs_in_if.sink    in_ch,
    ufs_out_if.source out_ch,
    ufs_cfg_if.sink   cfg_ch
);
    import ufs_pkg::*;

    // replacement byte register
    byte_t      replace_reg;

    // handshake between decode and result stages
    logic       take;
    logic       push;
    ufs_burst_t burst;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replace_reg <= REPLACE_RESET;
        else if (cfg_ch.valid && cfg_ch.ready)
            replace_reg <= cfg_ch.replacement_byte;
    end

    // input register, sequence state and per-item decode
    ufs_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .replace_byte (replace_reg),
        .take         (take),
        .push         (push),
        .burst        (burst)
    );

    // result register, sends one result per cycle while out_ch is ready
    ufs_serializer u_serializer (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .burst  (burst),
        .take   (take),
        .out_ch (out_ch)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ufs_pkg::*;

    // code point ranges that get replaced, upper bounds exclusive
    localparam logic [CP_W-1:0] PICTO_FIRST  = 21'h1F000;
    localparam logic [CP_W-1:0] PICTO_END    = 21'h1FFFF;
    localparam logic [CP_W-1:0] DINGBAT_FIRST = 21'h02700;
    localparam logic [CP_W-1:0] DINGBAT_END   = 21'h027BF;
    localparam logic [CP_W-1:0] TECHSYM_FIRST = 21'h02300;
    localparam logic [CP_W-1:0] TECHSYM_END   = 21'h024FF;

    // random items per phase, three random phases
    localparam int PHASE_ITEMS = 62;
    // cycles an item with no result may still be in flight
    localparam int SETTLE_CYCLES = 6;

    // one expected item on the output channel
    typedef struct {
        byte_t data;
        logic  has_byte;
        logic  last;
        logic  end_mark;
    } filt_out_t;

    // decodes the byte stream as the block should and holds the bytes still due
    class strip_scoreboard;
        byte_t            held [HELD_DEPTH];
        logic [CP_W-1:0]  acc;
        logic [LEN_W-1:0] want_len;
        logic [1:0]       got;
        byte_t            repl;
        filt_out_t        due_q [$];
        int               errors;
        int               outs_seen;

        function new();
            foreach (held[i])
                held[i] = '0;
            drop_sequence();
            repl      = REPLACE_RESET;
            errors    = 0;
            outs_seen = 0;
        endfunction

        function void drop_sequence();
            acc      = '0;
            want_len = LEN_NONE;
            got      = '0;
        endfunction

        function void set_replacement(byte_t b);
            repl = b;
        endfunction

        function int due_count();
            return due_q.size();
        endfunction

        function bit symbol_code_point(logic [CP_W-1:0] cp);
            return (cp >= PICTO_FIRST && cp < PICTO_END) ||
                   (cp >= DINGBAT_FIRST && cp < DINGBAT_END) ||
                   (cp >= TECHSYM_FIRST && cp < TECHSYM_END);
        endfunction

        function void push_due(byte_t d, logic v, logic l, logic e);
            filt_out_t w;
            w.data     = d;
            w.has_byte = v;
            w.last     = l;
            w.end_mark = e;
            due_q.insert(due_q.size(), w);
        endfunction

        function void begin_sequence(byte_t b, logic [LEN_W-1:0] len,
                                     logic [CP_W-1:0] bits);
            held[0]  = b;
            got      = 2'd1;
            want_len = len;
            acc      = bits;
        endfunction

        // sequence complete: original bytes or the replacement
        function void emit_code_point(byte_t b);
            if (symbol_code_point(acc))
                push_due(repl, 1'b1, 1'b1, 1'b0);
            else
            begin
                for (int i = 0; i < int'(got); i++)
                    push_due(held[i], 1'b1, 1'b0, 1'b0);
                push_due(b, 1'b1, 1'b1, 1'b0);
            end
            drop_sequence();
        endfunction

        function void note_input(byte_t b, logic eot);
            if (eot)
            begin
                drop_sequence();
                push_due(8'h00, 1'b0, 1'b1, 1'b1);
                return;
            end
            if (want_len != LEN_NONE)
            begin
                if ((b & CONT_MASK) == CONT_PAT)
                begin
                    acc = {acc[CP_W-7:0], b[5:0]};
                    if (int'(got) + 1 >= int'(want_len))
                        emit_code_point(b);
                    else if (got < 2'd3)
                    begin
                        held[got] = b;
                        got       = got + 2'd1;
                    end
                    else
                        drop_sequence();
                    return;
                end
                // cut short, this byte starts afresh
                drop_sequence();
            end
            if ((b & ASCII_MASK) == '0)
                push_due(b, 1'b1, 1'b1, 1'b0);
            else if ((b & LEAD2_MASK) == LEAD2_PAT)
                begin_sequence(b, LEN_TWO, CP_W'(b[4:0]));
            else if ((b & LEAD3_MASK) == LEAD3_PAT)
                begin_sequence(b, LEN_THREE, CP_W'(b[3:0]));
            else if ((b & LEAD4_MASK) == LEAD4_PAT)
                begin_sequence(b, LEN_FOUR, CP_W'(b[2:0]));
            // stray continuation and invalid leads fall through silently
        endfunction

        function void check_result(byte_t d, logic v, logic l, logic e);
            filt_out_t w;
            outs_seen++;
            if (due_q.size() == 0)
            begin
                $error("out_byte %02h arrived with nothing expected", d);
                errors++;
                return;
            end
            w = due_q[0];
            due_q.delete(0);
            if (d !== w.data)
            begin
                $error("out_byte: expected %02h, actual %02h", w.data, d);
                errors++;
            end
            if (v !== w.has_byte)
            begin
                $error("byte_valid: expected %0b, actual %0b", w.has_byte, v);
                errors++;
            end
            if (l !== w.last)
            begin
                $error("run_last: expected %0b, actual %0b", w.last, l);
                errors++;
            end
            if (e !== w.end_mark)
            begin
                $error("text_end: expected %0b, actual %0b", w.end_mark, e);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ufs_in_if  in_ch ();
    ufs_out_if out_ch ();
    ufs_cfg_if cfg_ch ();

    strip_scoreboard sb = new();

    // no_gaps turns off idling on both sides for a whole phase
    bit no_gaps;
    int items_fed;
    int ignored_fed;
    int settings_used;

    utf8_emoji_strip_filter_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // output side: check every accepted item, then maybe stall a few cycles
    initial
    begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.out_byte, out_ch.byte_valid,
                                out_ch.run_last, out_ch.text_end);
                hold = no_gaps ? 0 : $urandom_range(0, 4);
            end
            else if (hold != 0)
                hold--;
            out_ch.ready <= (hold == 0);
        end
    end

    // one input item, with a random gap ahead of it
    task automatic push_item(input byte_t b, input logic eot);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_text <= eot;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sb.note_input(b, eot);
        items_fed++;
    endtask

    // hold the input until every due result is out and the pipe is empty
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_replacement(input byte_t b);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.replacement_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_replacement(b);
        settings_used++;
    endtask

    // encode cp in n bytes and send the first cut of them
    task automatic send_code_point(input logic [CP_W-1:0] cp, input int n, input int cut);
        byte_t enc [4];
        for (int k = 1; k < n; k++)
            enc[k] = CONT_PAT | byte_t'((cp >> (6 * (n - 1 - k))) & 21'h3F);
        case (n)
            1:       enc[0] = byte_t'(cp[6:0]);
            2:       enc[0] = LEAD2_PAT | byte_t'(cp >> 6);
            3:       enc[0] = LEAD3_PAT | byte_t'(cp >> 12);
            default: enc[0] = LEAD4_PAT | byte_t'(cp >> 18);
        endcase
        for (int i = 0; i < cut; i++)
            push_item(enc[i], 1'b0);
    endtask

    // code point biased toward the replaced ranges and their bounds
    function automatic void pick_code_point(output logic [CP_W-1:0] cp, output int n);
        int nmin;
        logic [CP_W-1:0] bound;
        case ($urandom_range(0, 9))
            0, 1: cp = CP_W'($urandom_range(0, 8'h7F));
            2:    cp = CP_W'($urandom_range(12'h080, 12'h7FF));
            3:    cp = CP_W'($urandom_range(16'h0800, 16'hFFFF));
            4:    cp = CP_W'($urandom_range(16'h22F0, 16'h2510));
            5:    cp = CP_W'($urandom_range(16'h26F0, 16'h27D0));
            6:    cp = CP_W'($urandom_range(21'h1EFF0, 21'h20010));
            7:    cp = CP_W'($urandom_range(21'h10000, 21'h1FFFFF));
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       bound = PICTO_FIRST;
                    1:       bound = PICTO_END;
                    2:       bound = DINGBAT_FIRST;
                    3:       bound = DINGBAT_END;
                    4:       bound = TECHSYM_FIRST;
                    default: bound = TECHSYM_END;
                endcase
                cp = bound + CP_W'($urandom_range(0, 2)) - CP_W'(1);
            end
            default: cp = CP_W'($urandom_range(21'h1F000, 21'h1FFFE));
        endcase
        if (cp < 21'h80)
            nmin = 1;
        else if (cp < 21'h800)
            nmin = 2;
        else if (cp < 21'h10000)
            nmin = 3;
        else
            nmin = 4;
        // now and then an overlong form, which passes undetected
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(nmin, 4) : nmin;
    endfunction

    // mostly well-formed text, the rest broken sequences and noise
    task automatic random_phase();
        int start;
        int kind;
        int n;
        logic [CP_W-1:0] cp;
        start = items_fed - ignored_fed;
        while (items_fed - ignored_fed - start < PHASE_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
            begin
                pick_code_point(cp, n);
                send_code_point(cp, n, n);
            end
            else if (kind < 16)
            begin
                // truncated sequence, next item decides how it ends
                pick_code_point(cp, n);
                if (n == 1)
                    n = 2 + $urandom_range(0, 2);
                send_code_point(cp & ((21'h1 << (5 * n + 1)) - 1), n,
                                $urandom_range(1, n - 1));
            end
            else if (kind == 16)
                push_item(byte_t'($urandom_range(0, 255)), 1'b1);
            else if (kind == 17)
            begin
                push_item(byte_t'($urandom_range(8'h80, 8'hBF)), 1'b0);
                ignored_fed++;
            end
            else if (kind == 18)
            begin
                push_item(byte_t'($urandom_range(8'hF8, 8'hFF)), 1'b0);
                ignored_fed++;
            end
            else
            begin
                push_item(byte_t'($urandom_range(0, 255)), 1'b0);
                // occasional full stop on the sender
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
        end
    endtask

    // directed bytes: ascii extremes and zero, 2/3/4-byte passes and
    // replacements at range bounds, stray continuation, invalid leads,
    // a sequence cut short by ascii
    byte_t directed [] = '{8'h00, 8'h7F,
                           8'hDF, 8'hBF,
                           8'hE2, 8'h8C, 8'h80,
                           8'hE2, 8'h93, 8'hBF,
                           8'hF0, 8'h9F, 8'h98, 8'h80,
                           8'hF0, 8'h9F, 8'hBF, 8'hBF,
                           8'h80, 8'hF8, 8'hFF,
                           8'hE2, 8'h41};

    initial
    begin
        byte_t phase_repl [3];
        phase_repl[0] = 8'h00;
        phase_repl[1] = 8'hFF;
        phase_repl[2] = byte_t'($urandom_range(1, 254));

        no_gaps       = 1'b0;
        items_fed     = 0;
        ignored_fed   = 0;
        settings_used = 1;

        rst_n                   <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.data_byte         <= '0;
        in_ch.end_of_text       <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.replacement_byte <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset replacement byte
        foreach (directed[i])
            push_item(directed[i], 1'b0);
        // end of text in the middle of a 4-byte sequence
        push_item(8'hF0, 1'b0);
        push_item(8'h9F, 1'b0);
        push_item(8'hA5, 1'b1);
        wait_drained();

        // random phases, each under its own replacement byte;
        // the second one runs with no idling at all
        for (int p = 0; p < 3; p++)
        begin
            load_replacement(phase_repl[p]);
            no_gaps = (p == 1);
            random_phase();
            no_gaps = 1'b0;
            wait_drained();
        end

        $display("fed %0d input items (%0d ignored bytes), checked %0d results",
                 items_fed, ignored_fed, sb.outs_seen);
        $display("used %0d replacement byte settings incl. 00 and ff", settings_used);
        if (sb.errors == 0 && sb.due_count() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_in_if.sv
hw/rtl/ufs_out_if.sv
hw/rtl/ufs_cfg_if.sv
hw/rtl/ufs_decoder.sv
hw/rtl/ufs_serializer.sv
hw/rtl/utf8_emoji_strip_filter_top.sv
bench/testbench.sv
